/* rtl/bra_pkg.sv */
package bra_pkg;

	// Command kinds carried in s_tuser.
	localparam logic [2:0] KIND_CLEAR_ALL = 3'd0;
	localparam logic [2:0] KIND_TEST_BIT  = 3'd1;
	localparam logic [2:0] KIND_SET_BIT   = 3'd2;
	localparam logic [2:0] KIND_CLEAR_BIT = 3'd3;
	localparam logic [2:0] KIND_FIND_RUN  = 3'd4;

	localparam int KIND_W   = 3;
	localparam int INDEX_W  = 10;
	localparam int RUN_W    = 11;
	localparam int USED_W   = 8;
	localparam int BYTE_W   = 8;
	localparam int POS_W    = 3;

	localparam logic [USED_W-1:0] USED_RESET = 8'd128;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BITOP,
		ST_SCAN,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic             hit;
		logic [POS_W-1:0] pos;
		logic [RUN_W-1:0] cnt;
	} scan_step_t;

	// Walks the eight bits of one map byte, lowest bit first, and extends the
	// current free run. Stops counting at the first bit where the run reaches len.
	function automatic scan_step_t scan_byte(input logic [BYTE_W-1:0] b,
	                                         input logic [RUN_W-1:0] cnt,
	                                         input logic [RUN_W-1:0] len);
		scan_step_t r;
		logic [RUN_W-1:0] c;
		r.hit = 1'b0;
		r.pos = '0;
		c = cnt;
		for (int j = 0; j < BYTE_W; j++) begin
			if (!r.hit) begin
				if (b[j]) begin
					c = '0;
				end else begin
					c = c + RUN_W'(1);
				end
				if (c == len) begin
					r.hit = 1'b1;
					r.pos = POS_W'(j);
				end
			end
		end
		r.cnt = c;
		return r;
	endfunction

endpackage

/* rtl/bitmap_run_allocator.sv */
// First-fit bitmap allocator.
// Input channel s_*: one command item per handshake; s_tuser holds the kind
// (clear all, test, set, clear, find run) and s_tdata the bit index and run length.
// Output channel m_*: exactly one result item per command, in order.
// cfg_wen/cfg_wdata write used_bytes, the number of map bytes that a find scans.
// The map lives in a byte-wide memory with one write and one registered read port.
// Test, set and clear pass through a bit-operation state before the result state;
// an unused kind, a zero run length or an empty scan range goes straight to it;
// a find walks the scanned bytes until a hit, and the scan loop takes one byte
// per cycle through the read port; clear all sweeps all MAP_BYTES bytes and
// writes one byte per cycle. One command is in work at a time; s_tready is high
// only while the block is idle.
// After reset the map is cleared by a sweep over all MAP_BYTES bytes, during which
// s_tready stays low; used_bytes resets to 128.
// A finished result sits in an output register. The block takes the next command
// while it waits; if the receiver stalls, that command's result is held back
// until the register is free.
module bitmap_run_allocator
	import bra_pkg::*;
#(
	parameter int MAP_BYTES = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // bit_index [9:0], run_length [20:10], zero pad
	input  logic [7:0]  s_tuser,   // kind [2:0], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // bit_value [0], start_index [10:1], zero pad
	output logic [7:0]  m_tuser,   // found [0], zero pad
	input  logic        cfg_wen,
	input  logic [7:0]  cfg_wdata
);

	localparam int AW  = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
	localparam int NBW = $clog2(MAP_BYTES + 1);
	localparam int CW  = (NBW > USED_W) ? NBW : USED_W;
	localparam logic [CW-1:0] MAP_BYTES_C = CW'(MAP_BYTES);
	localparam logic [AW-1:0] LAST_ADDR   = AW'(MAP_BYTES - 1);

	logic [BYTE_W-1:0] mem [MAP_BYTES];

	state_t state_q, state_d;

	logic [USED_W-1:0]  used_q;
	logic [AW-1:0]      clr_cnt_q;
	logic               clr_cmd_q;
	logic [KIND_W-1:0]  op_q;
	logic [POS_W-1:0]   bitpos_q;
	logic               byte_ok_q;
	logic [AW-1:0]      addr_q;
	logic [RUN_W-1:0]   cnt_q;
	logic [RUN_W-1:0]   len_q;
	logic [BYTE_W-1:0]  rdata_q;
	logic               res_bit_q;
	logic               res_found_q;
	logic [INDEX_W-1:0] res_start_q;
	logic               m_tvalid_q;
	logic               m_bit_q;
	logic               m_found_q;
	logic [INDEX_W-1:0] m_start_q;

	logic [KIND_W-1:0]  in_kind;
	logic [INDEX_W-1:0] in_index;
	logic [RUN_W-1:0]   in_len;
	logic [CW-1:0]      in_byte_c;
	logic [AW-1:0]      in_addr;
	logic               in_byte_ok;
	logic [CW-1:0]      nbytes_c;
	logic [CW-1:0]      next_count_c;
	logic               scan_last;
	logic               accept;
	logic               out_load;
	logic               find_empty;
	scan_step_t         step;
	logic [INDEX_W-1:0] start_c;
	logic [6:0]         addr_lo;
	logic [BYTE_W-1:0]  bit_mask;

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [BYTE_W-1:0]  mem_wdata;
	logic [AW-1:0]      mem_raddr;

	assign in_kind    = s_tuser[KIND_W-1:0];
	assign in_index   = s_tdata[INDEX_W-1:0];
	assign in_len     = s_tdata[INDEX_W+RUN_W-1:INDEX_W];
	assign in_byte_c  = CW'(in_index[INDEX_W-1:POS_W]);
	assign in_addr    = in_byte_c[AW-1:0];
	assign in_byte_ok = in_byte_c < MAP_BYTES_C;

	assign nbytes_c     = (CW'(used_q) > MAP_BYTES_C) ? MAP_BYTES_C : CW'(used_q);
	assign next_count_c = CW'(addr_q) + CW'(1);
	assign scan_last    = next_count_c >= nbytes_c;
	assign find_empty   = (in_len == '0) || (nbytes_c == '0);

	assign accept   = s_tvalid && s_tready;
	assign out_load = !m_tvalid_q || m_tready;

	assign step     = scan_byte(rdata_q, cnt_q, len_q);
	assign addr_lo  = 7'(addr_q);
	assign start_c  = {addr_lo, 3'b000} + INDEX_W'(step.pos) + INDEX_W'(1)
	                  - len_q[INDEX_W-1:0];
	assign bit_mask = BYTE_W'(1) << bitpos_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == LAST_ADDR) begin
					state_d = clr_cmd_q ? ST_RESULT : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					unique case (in_kind)
						KIND_CLEAR_ALL: state_d = ST_CLEAR;
						KIND_TEST_BIT,
						KIND_SET_BIT,
						KIND_CLEAR_BIT: state_d = ST_BITOP;
						KIND_FIND_RUN:  state_d = find_empty ? ST_RESULT : ST_SCAN;
						default:        state_d = ST_RESULT;
					endcase
				end
			end
			ST_BITOP: state_d = ST_RESULT;
			ST_SCAN: begin
				if (step.hit || scan_last) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory ports and handshake.
	always_comb begin
		s_tready  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = rdata_q;
		mem_raddr = addr_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_cnt_q;
				mem_wdata = '0;
			end
			ST_IDLE: begin
				s_tready  = 1'b1;
				mem_raddr = (in_kind == KIND_FIND_RUN) ? '0 : in_addr;
			end
			ST_BITOP: begin
				mem_we    = byte_ok_q && (op_q != KIND_TEST_BIT);
				mem_wdata = (op_q == KIND_SET_BIT) ? (rdata_q | bit_mask)
				                                   : (rdata_q & ~bit_mask);
			end
			ST_SCAN: begin
				// Fetch the next byte while this one is examined.
				mem_raddr = addr_q + AW'(1);
			end
			ST_RESULT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_cnt_q  <= '0;
			clr_cmd_q  <= 1'b0;
			used_q     <= USED_RESET;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wen) begin
				used_q <= cfg_wdata;
			end
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end else begin
				clr_cnt_q <= '0;
			end
			if (accept) begin
				clr_cmd_q <= (in_kind == KIND_CLEAR_ALL);
			end
			if (state_q == ST_RESULT && out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Command and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q        <= in_kind;
			bitpos_q    <= in_index[POS_W-1:0];
			byte_ok_q   <= in_byte_ok;
			addr_q      <= (in_kind == KIND_FIND_RUN) ? '0 : in_addr;
			cnt_q       <= '0;
			len_q       <= in_len;
			res_bit_q   <= 1'b0;
			res_found_q <= 1'b0;
			res_start_q <= '0;
		end
		if (state_q == ST_BITOP && op_q == KIND_TEST_BIT) begin
			res_bit_q <= byte_ok_q && rdata_q[bitpos_q];
		end
		if (state_q == ST_SCAN) begin
			cnt_q  <= step.cnt;
			addr_q <= addr_q + AW'(1);
			if (step.hit) begin
				res_found_q <= 1'b1;
				res_start_q <= start_c;
			end
		end
		if (state_q == ST_RESULT && out_load) begin
			m_bit_q   <= res_bit_q;
			m_found_q <= res_found_q;
			m_start_q <= res_start_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'd0, m_start_q, m_bit_q};
	assign m_tuser  = {7'd0, m_found_q};

endmodule

/* rtl/bra_checker.sv */
module bra_checker
	import bra_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [7:0]  m_tuser
);

	// Every command occupies the block: s_tready is low in the cycle after an accept.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while a command was in work");

	// A result that is not found reports start index zero.
	a_start_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[10:1] == '0)
		else $error("nonzero start index without a found run");

	// A result never reports both a set bit value and a found run.
	a_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tdata[0]))
		else $error("bit value and found both set");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind bitmap_run_allocator bra_checker u_bra_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

/* sim/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
	import bra_pkg::*;

	localparam int MAP_BYTES = 128;
	localparam int MAP_BITS  = MAP_BYTES * BYTE_W;

	// Kinds with no defined action; the block must answer them with an all-zero item.
	localparam logic [KIND_W-1:0] KIND_UNUSED_FIRST = 3'd5;
	localparam logic [KIND_W-1:0] KIND_UNUSED_LAST  = 3'd7;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [INDEX_W-1:0] bit_index;
		logic [RUN_W-1:0]   run_length;
	} command_t;

	typedef struct packed {
		logic               bit_value;
		logic               found;
		logic [INDEX_W-1:0] start_index;
	} alloc_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic [7:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic [7:0]  m_tuser;
	logic        cfg_wen;
	logic [7:0]  cfg_wdata;

	command_t      pending_cmds[$];
	alloc_result_t expected_replies[$];
	logic [BYTE_W-1:0] shadow_map [MAP_BYTES];
	logic [USED_W-1:0] used_cfg = USED_RESET;
	logic cmd_fire = 1'b0;
	logic hold_results = 1'b0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int error_count = 0;

	bitmap_run_allocator #(
		.MAP_BYTES(MAP_BYTES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic int scanned_bits();
		return ((int'(used_cfg) > MAP_BYTES) ? MAP_BYTES : int'(used_cfg)) * BYTE_W;
	endfunction

	// Applies one command to the shadow map and returns the item the block should send.
	function automatic alloc_result_t apply_to_shadow_map(logic [KIND_W-1:0] kind,
	                                                       logic [INDEX_W-1:0] idx,
	                                                       logic [RUN_W-1:0] len);
		alloc_result_t r;
		int scan_bits;
		int free_run;
		r = '0;
		scan_bits = scanned_bits();
		free_run = 0;
		case (kind)
			KIND_CLEAR_ALL: begin
				foreach (shadow_map[b]) shadow_map[b] = '0;
			end
			KIND_TEST_BIT: begin
				if (int'(idx) < MAP_BITS) r.bit_value = shadow_map[idx / BYTE_W][idx % BYTE_W];
			end
			KIND_SET_BIT: begin
				if (int'(idx) < MAP_BITS) shadow_map[idx / BYTE_W][idx % BYTE_W] = 1'b1;
			end
			KIND_CLEAR_BIT: begin
				if (int'(idx) < MAP_BITS) shadow_map[idx / BYTE_W][idx % BYTE_W] = 1'b0;
			end
			KIND_FIND_RUN: begin
				if (len != 0 && int'(len) <= scan_bits) begin
					for (int i = 0; i < scan_bits && !r.found; i++) begin
						if (shadow_map[i / BYTE_W][i % BYTE_W]) free_run = 0;
						else free_run++;
						if (free_run == int'(len)) begin
							r.found = 1'b1;
							r.start_index = INDEX_W'(i + 1 - int'(len));
						end
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Most indices land in a small window at the bottom of the map so that sets
	// and clears build up fragmented patterns that the finds then have to walk.
	function automatic command_t random_command();
		command_t c;
		int scan_bits;
		int window;
		int pick;
		scan_bits = scanned_bits();
		window = (scan_bits == 0 || scan_bits > 64) ? 64 : scan_bits;
		pick = $urandom_range(0, 99);
		if (pick < 70) c.bit_index = INDEX_W'($urandom_range(0, window - 1));
		else if (pick < 85 && scan_bits != 0) c.bit_index = INDEX_W'($urandom_range(0, scan_bits - 1));
		else c.bit_index = INDEX_W'($urandom_range(0, MAP_BITS - 1));
		c.run_length = RUN_W'($urandom_range(0, 2047));
		pick = $urandom_range(0, 99);
		if (pick < 2) c.kind = KIND_CLEAR_ALL;
		else if (pick < 5) c.kind = KIND_W'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
		else if (pick < 32) c.kind = KIND_SET_BIT;
		else if (pick < 50) c.kind = KIND_CLEAR_BIT;
		else if (pick < 68) c.kind = KIND_TEST_BIT;
		else begin
			c.kind = KIND_FIND_RUN;
			pick = $urandom_range(0, 99);
			if (pick < 70) c.run_length = RUN_W'($urandom_range(1, 12));
			else if (pick < 88) c.run_length = RUN_W'($urandom_range(0, scan_bits + 2));
			else if (pick < 94) c.run_length = '0;
		end
		return c;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
		error_count++;
	endtask

	task automatic queue_cmd(logic [KIND_W-1:0] kind, int idx, int len);
		pending_cmds.push_back('{kind, INDEX_W'(idx), RUN_W'(len)});
	endtask

	task automatic wait_quiet();
		while (pending_cmds.size() != 0 || s_tvalid || expected_replies.size() != 0)
			@(negedge clk);
	endtask

	// Waits until nothing is in flight, so the shadow copy can change at once.
	task automatic write_used(logic [USED_W-1:0] value);
		wait_quiet();
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= value;
		used_cfg = value;
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic run_random_phase(logic [USED_W-1:0] used, int idle_pct, int stall_pct,
	                                int count);
		write_used(used);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) pending_cmds.push_back(random_command());
	endtask

	// Command driver: holds an item until it is taken, then offers the next one.
	always @(negedge clk) begin : drive_commands
		command_t next_cmd;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || cmd_fire) begin
			if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				next_cmd = pending_cmds.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= {5'd0, next_cmd.kind};
				s_tdata <= {3'd0, next_cmd.run_length, next_cmd.bit_index};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_results) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Predicts on every accepted command and checks every accepted result item.
	always @(posedge clk) begin : track_and_check
		alloc_result_t want;
		cmd_fire <= arst_n && s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) begin
			expected_replies.push_back(apply_to_shadow_map(s_tuser[KIND_W-1:0],
				s_tdata[INDEX_W-1:0], s_tdata[INDEX_W +: RUN_W]));
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_replies.size() == 0) begin
				report_mismatch("unexpected result item, start_index", m_tdata[10:1], 0);
			end else begin
				want = expected_replies.pop_front();
				if (m_tdata[0] !== want.bit_value)
					report_mismatch("bit_value", m_tdata[0], want.bit_value);
				if (m_tuser[0] !== want.found)
					report_mismatch("found", m_tuser[0], want.found);
				if (m_tdata[10:1] !== want.start_index)
					report_mismatch("start_index", m_tdata[10:1], want.start_index);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		foreach (shadow_map[b]) shadow_map[b] = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, first on the reset value of used_bytes.
		queue_cmd(KIND_FIND_RUN, 0, 1);
		queue_cmd(KIND_FIND_RUN, 0, MAP_BITS);
		queue_cmd(KIND_FIND_RUN, 0, MAP_BITS + 1);
		queue_cmd(KIND_FIND_RUN, 1023, 0);
		queue_cmd(KIND_FIND_RUN, 0, 2047);
		queue_cmd(KIND_SET_BIT, 0, 0);
		queue_cmd(KIND_SET_BIT, 1023, 2047);
		queue_cmd(KIND_TEST_BIT, 0, 0);
		queue_cmd(KIND_TEST_BIT, 1023, 0);
		queue_cmd(KIND_TEST_BIT, 512, 0);
		queue_cmd(KIND_FIND_RUN, 0, MAP_BITS - 2);
		queue_cmd(KIND_FIND_RUN, 0, MAP_BITS - 1);
		queue_cmd(KIND_CLEAR_BIT, 1023, 0);
		queue_cmd(KIND_TEST_BIT, 1023, 0);
		queue_cmd(KIND_UNUSED_FIRST, 1023, 2047);
		queue_cmd(KIND_UNUSED_FIRST + 3'd1, 1023, 2047);
		queue_cmd(KIND_UNUSED_LAST, 0, 1);
		queue_cmd(KIND_CLEAR_ALL, 1023, 2047);
		queue_cmd(KIND_TEST_BIT, 0, 0);

		// An empty scan range never finds anything, even on a clear map.
		write_used(8'd0);
		queue_cmd(KIND_FIND_RUN, 0, 1);
		// A used length above the map scans only the bytes that exist.
		write_used(8'd255);
		queue_cmd(KIND_FIND_RUN, 0, MAP_BITS);
		queue_cmd(KIND_FIND_RUN, 0, MAP_BITS + 1);
		write_used(8'd1);
		queue_cmd(KIND_SET_BIT, 3, 0);
		queue_cmd(KIND_FIND_RUN, 0, 4);
		queue_cmd(KIND_FIND_RUN, 0, 5);

		run_random_phase(8'd128, 0, 0, 100);
		run_random_phase(8'd4, 78, 0, 100);
		run_random_phase(8'd1, 0, 78, 80);
		run_random_phase(8'd16, 26, 26, 100);
		run_random_phase(8'd255, 0, 0, 80);
		run_random_phase(8'd0, 78, 0, 40);

		// Receiver holds off for a long stretch while commands keep coming.
		run_random_phase(8'd32, 0, 0, 0);
		hold_results = 1'b1;
		repeat (60) pending_cmds.push_back(random_command());
		repeat (400) @(posedge clk);
		hold_results = 1'b0;

		run_random_phase(8'd8, 0, 78, 100);
		run_random_phase(8'd128, 26, 26, 100);
		run_random_phase(8'd2, 0, 0, 80);
		run_random_phase(8'd64, 78, 0, 80);
		run_random_phase(8'd128, 0, 78, 60);

		wait_quiet();
		repeat (MAP_BYTES + 20) @(posedge clk);
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
